// ===== rtl/core/fwct_pkg.sv =====
package fwct_pkg;

    localparam int RAW_W            = 32;
    localparam int DIV_W            = 16;
    localparam int LIMIT_W          = 32;
    localparam int SAMPLES_W        = 8;
    localparam int CEIL_W           = 32;
    localparam int OUT_W            = 32;
    localparam int PHASE_W          = 3;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 32;
    localparam int WEIGHT_WIDTH_DEF = 32;

    localparam logic [PHASE_W-1:0] PH_POWER_ON   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_JUDGE      = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CONFIRM_DEC = 3'd2;
    localparam logic [PHASE_W-1:0] PH_CONFIRM_INC = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DECREASE   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_INCREASE   = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNIT_DIVISOR    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANGE_LIMIT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONFIRM_SAMPLES = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_CEILING   = 2'd3;

    typedef struct packed {
        logic [DIV_W-1:0]     unit_divisor;
        logic [LIMIT_W-1:0]   change_limit;
        logic [SAMPLES_W-1:0] confirm_samples;
        logic [CEIL_W-1:0]    total_ceiling;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               powered;
        logic [OUT_W-1:0]   total;
    } track_status_t;

endpackage

// ===== rtl/core/fwct_div.sv =====
module fwct_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fwct_pkg::RAW_W-1:0]    dividend,
    input  logic [fwct_pkg::DIV_W-1:0]    divisor,
    output logic                          done,
    output logic [fwct_pkg::RAW_W-1:0]    quotient
);

    localparam int STEPS = fwct_pkg::RAW_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam int DW    = fwct_pkg::DIV_W;
    localparam int QW    = fwct_pkg::RAW_W;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    dvs_reg;
    logic [QW-1:0]    quo_reg;

    logic [DW:0]      shifted;
    logic [DW+1:0]    trial;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[QW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = ~trial[DW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[DW-1:0] : shifted[DW-1:0];
            quo_reg <= {quo_reg[QW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/fwct_track.sv =====
module fwct_track
#(
    parameter int WEIGHT_WIDTH = fwct_pkg::WEIGHT_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [WEIGHT_WIDTH-1:0]  now,
    input  logic                     err,
    input  fwct_pkg::cfg_t           cfg,
    output logic                     done,
    output fwct_pkg::track_status_t  status
);

    localparam int UW = (WEIGHT_WIDTH > 32) ? WEIGHT_WIDTH : 32;
    localparam int SW = fwct_pkg::SAMPLES_W;
    localparam int PW = fwct_pkg::PHASE_W;

    localparam logic [2:0] T_IDLE   = 3'd0;
    localparam logic [2:0] T_DIFF   = 3'd1;
    localparam logic [2:0] T_LIMIT  = 3'd2;
    localparam logic [2:0] T_CEIL   = 3'd3;
    localparam logic [2:0] T_SUB    = 3'd4;
    localparam logic [2:0] T_COMMIT = 3'd5;

    logic [2:0]              step_reg, step_next;
    logic                    done_reg;
    logic [PW-1:0]           phase_reg, phase_next;
    logic [WEIGHT_WIDTH-1:0] ref_reg, ref_next;
    logic [SW-1:0]           cnt_reg, cnt_next;
    logic [WEIGHT_WIDTH-1:0] total_reg, total_next;
    logic                    powered_reg, powered_next;

    logic [WEIGHT_WIDTH-1:0] now_reg;
    logic                    err_reg;
    logic [WEIGHT_WIDTH-1:0] diff_reg;
    logic [WEIGHT_WIDTH-1:0] sum_reg;
    logic                    gt_reg;
    logic                    over_reg;
    logic                    ceil_over_reg;

    logic [UW-1:0]           alu_a;
    logic [UW-1:0]           alu_b;
    logic                    alu_sub;
    logic [UW:0]             alu_sum;
    logic                    alu_carry;
    logic [WEIGHT_WIDTH-1:0] alu_res;
    logic [SW-1:0]           cnt_inc;

    // One adder serves every difference and sum of the update and its weight compares.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        case (step_reg)
            T_DIFF:
            begin
                if (phase_reg == fwct_pkg::PH_CONFIRM_INC)
                begin
                    alu_a = UW'(now_reg);
                    alu_b = UW'(ref_reg);
                end
                else
                begin
                    alu_a = UW'(ref_reg);
                    alu_b = UW'(now_reg);
                end
            end
            T_LIMIT:
            begin
                if (phase_reg == fwct_pkg::PH_DECREASE)
                begin
                    alu_a   = UW'(total_reg);
                    alu_b   = UW'(diff_reg);
                    alu_sub = 1'b0;
                end
                else
                begin
                    alu_a = UW'(cfg.change_limit);
                    alu_b = UW'(diff_reg);
                end
            end
            T_CEIL:
            begin
                alu_a = UW'(cfg.total_ceiling);
                alu_b = UW'(sum_reg);
            end
            T_SUB:
            begin
                alu_a = UW'(sum_reg);
                alu_b = UW'(cfg.total_ceiling);
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_sub ? ~alu_b : alu_b} + {{UW{1'b0}}, alu_sub};
    assign alu_carry = alu_sum[UW];
    assign alu_res   = alu_sum[WEIGHT_WIDTH-1:0];
    assign cnt_inc   = (cnt_reg < cfg.confirm_samples) ? cnt_reg + 1'b1 : cnt_reg;

    always_comb
    begin
        step_next = step_reg;
        case (step_reg)
            T_IDLE:   step_next = start ? T_DIFF : T_IDLE;
            T_DIFF:   step_next = T_LIMIT;
            T_LIMIT:  step_next = T_CEIL;
            T_CEIL:   step_next = T_SUB;
            T_SUB:    step_next = T_COMMIT;
            T_COMMIT: step_next = T_IDLE;
            default:  step_next = T_IDLE;
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        ref_next     = ref_reg;
        cnt_next     = cnt_reg;
        total_next   = total_reg;
        powered_next = powered_reg;
        if (step_reg == T_COMMIT && !err_reg)
        begin
            case (phase_reg)
                fwct_pkg::PH_POWER_ON:
                begin
                    ref_next     = now_reg;
                    powered_next = 1'b1;
                    phase_next   = fwct_pkg::PH_JUDGE;
                end
                fwct_pkg::PH_JUDGE:
                begin
                    cnt_next   = '0;
                    phase_next = gt_reg ? fwct_pkg::PH_CONFIRM_DEC : fwct_pkg::PH_CONFIRM_INC;
                end
                fwct_pkg::PH_CONFIRM_DEC, fwct_pkg::PH_CONFIRM_INC:
                begin
                    if (gt_reg)
                    begin
                        if (over_reg)
                        begin
                            cnt_next = cnt_inc;
                            if (cnt_inc == cfg.confirm_samples)
                            begin
                                phase_next = (phase_reg == fwct_pkg::PH_CONFIRM_DEC) ?
                                             fwct_pkg::PH_DECREASE : fwct_pkg::PH_INCREASE;
                            end
                        end
                    end
                    else
                    begin
                        phase_next = fwct_pkg::PH_JUDGE;
                        cnt_next   = '0;
                    end
                end
                fwct_pkg::PH_DECREASE:
                begin
                    total_next = sum_reg;
                    ref_next   = now_reg;
                    phase_next = fwct_pkg::PH_JUDGE;
                end
                fwct_pkg::PH_INCREASE:
                begin
                    ref_next   = now_reg;
                    phase_next = fwct_pkg::PH_JUDGE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= T_IDLE;
            done_reg    <= 1'b0;
            phase_reg   <= fwct_pkg::PH_POWER_ON;
            ref_reg     <= '0;
            cnt_reg     <= '0;
            total_reg   <= '0;
            powered_reg <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            done_reg    <= (step_reg == T_COMMIT);
            phase_reg   <= phase_next;
            ref_reg     <= ref_next;
            cnt_reg     <= cnt_next;
            total_reg   <= total_next;
            powered_reg <= powered_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (step_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    now_reg <= now;
                    err_reg <= err;
                end
            end
            T_DIFF:
            begin
                diff_reg <= alu_res;
                gt_reg   <= alu_carry && (alu_res != '0);
            end
            T_LIMIT:
            begin
                if (phase_reg == fwct_pkg::PH_DECREASE)
                begin
                    sum_reg <= alu_res;
                end
                over_reg <= ~alu_carry;
            end
            T_CEIL:
            begin
                ceil_over_reg <= ~alu_carry;
            end
            T_SUB:
            begin
                if (ceil_over_reg)
                begin
                    sum_reg <= alu_res;
                end
            end
            default:
            begin
                err_reg <= err_reg;
            end
        endcase
    end

    assign done           = done_reg;
    assign status.phase   = phase_reg;
    assign status.powered = powered_reg;
    assign status.total   = fwct_pkg::OUT_W'(total_reg);

endmodule

// ===== rtl/core/feed_weight_change_tracker.sv =====
// Each accepted input beat passes through 32 radix-2 divider steps, then five
// steps of the shared-adder phase update, with hand-off cycles between the units;
// no new beat is taken until the current result is loaded into the output register.
// A result waits in the output register while the next beat is processed; the
// following result waits in the final state until the receiver takes the first.
// Reset (rst_n, asynchronous, active low) restores the register defaults and
// the power-on phase with zero reference, counter and consumed total.
module feed_weight_change_tracker
#(
    parameter int WEIGHT_WIDTH = fwct_pkg::WEIGHT_WIDTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fwct_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fwct_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [fwct_pkg::RAW_W-1:0]          raw_reading,
    input  logic                                system_error,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [fwct_pkg::OUT_W-1:0]          current_weight,
    output logic [fwct_pkg::OUT_W-1:0]          feed_total,
    output logic [fwct_pkg::PHASE_W-1:0]        phase,
    output logic                                powered_up
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_TRACK = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]                    state_reg, state_next;
    fwct_pkg::cfg_t                cfg_reg;
    logic                          err_reg;
    logic [WEIGHT_WIDTH-1:0]       now_reg;
    logic                          out_valid_reg;
    logic [fwct_pkg::OUT_W-1:0]    weight_out_reg;
    logic [fwct_pkg::OUT_W-1:0]    total_out_reg;
    logic [fwct_pkg::PHASE_W-1:0]  phase_out_reg;
    logic                          powered_out_reg;

    logic                          accept;
    logic                          div_done;
    logic [fwct_pkg::RAW_W-1:0]    quotient;
    logic [WEIGHT_WIDTH-1:0]       now_w;
    logic                          track_done;
    fwct_pkg::track_status_t       status;
    logic                          load_out;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);
    assign now_w    = (cfg_reg.unit_divisor == '0) ? '1 : WEIGHT_WIDTH'(quotient);

    fwct_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (raw_reading),
        .divisor  (cfg_reg.unit_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    fwct_track
    #(
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    )
    u_track
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_done),
        .now    (now_w),
        .err    (err_reg),
        .cfg    (cfg_reg),
        .done   (track_done),
        .status (status)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  state_next = accept ? ST_DIV : ST_IDLE;
            ST_DIV:   state_next = div_done ? ST_TRACK : ST_DIV;
            ST_TRACK: state_next = track_done ? ST_FIN : ST_TRACK;
            ST_FIN:   state_next = load_out ? ST_IDLE : ST_FIN;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                <= ST_IDLE;
            out_valid_reg            <= 1'b0;
            cfg_reg.unit_divisor     <= 16'd1;
            cfg_reg.change_limit     <= '0;
            cfg_reg.confirm_samples  <= 8'd3;
            cfg_reg.total_ceiling    <= '1;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    fwct_pkg::CFG_UNIT_DIVISOR:
                        cfg_reg.unit_divisor <= cfg_wdata[fwct_pkg::DIV_W-1:0];
                    fwct_pkg::CFG_CHANGE_LIMIT:
                        cfg_reg.change_limit <= cfg_wdata[fwct_pkg::LIMIT_W-1:0];
                    fwct_pkg::CFG_CONFIRM_SAMPLES:
                        cfg_reg.confirm_samples <= cfg_wdata[fwct_pkg::SAMPLES_W-1:0];
                    fwct_pkg::CFG_TOTAL_CEILING:
                        cfg_reg.total_ceiling <= cfg_wdata[fwct_pkg::CEIL_W-1:0];
                    default:
                        cfg_reg <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg <= system_error;
        end
        if (div_done)
        begin
            now_reg <= now_w;
        end
        if (load_out)
        begin
            weight_out_reg  <= fwct_pkg::OUT_W'(now_reg);
            total_out_reg   <= status.total;
            phase_out_reg   <= status.phase;
            powered_out_reg <= status.powered;
        end
    end

    assign out_valid      = out_valid_reg;
    assign current_weight = weight_out_reg;
    assign feed_total     = total_out_reg;
    assign phase          = phase_out_reg;
    assign powered_up     = powered_out_reg;

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("Divider finished outside the divide state.");

    a_track_done_in_track: assert property (@(posedge clk) disable iff (!rst_n)
        track_done |-> (state_reg == ST_TRACK))
        else $error("Tracker finished outside the track state.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("Input still ready right after a beat was accepted.");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid)
        else $error("Loaded result was not presented.");
`endif

endmodule
